// ===== rtl/smallest_prime_factor_prefix_sum_assert.svh =====
// Assertion helpers shared by the block's modules.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef SMALLEST_PRIME_FACTOR_PREFIX_SUM_ASSERT_SVH
`define SMALLEST_PRIME_FACTOR_PREFIX_SUM_ASSERT_SVH

// Same-cycle implication
`define SPFPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SPFPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spfps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spfps_pkg;

  // Fixed field widths
  localparam int unsigned QIDX_W = 16;
  localparam int unsigned SUM_W  = 48;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;      // latch request index
    logic issue;       // read sum table at latched index next cycle
    logic init_start;  // clear index counter
    logic init_step;   // write identity entry, advance
    logic p_start;     // p = 2, p*p = 4
    logic p_next;      // advance p and p*p
    logic rd_p;        // read factor[p]
    logic m_start;     // m = p*p
    logic rd_m;        // read factor[m]
    logic chk_m;       // mark m if unmarked, m += p
    logic ps_start;    // clear index counter for prefix pass
    logic ps_step;     // read factor[i] into prefix pipe, advance
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last;        // index counter at last entry
    logic p_done;      // p*p reached table size
    logic p_prime;     // factor[p] == p
    logic m_last;      // next multiple is past the table
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/spfps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spfps_ram #(
  parameter int unsigned W = 16,
  parameter int unsigned D = 65536
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic                 re_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spfps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "smallest_prime_factor_prefix_sum_assert.svh"

module spfps_ctrl import spfps_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_INIT  = 9'b000000010,
    S_PRD   = 9'b000000100,
    S_PCHK  = 9'b000001000,
    S_MRD   = 9'b000010000,
    S_MCHK  = 9'b000100000,
    S_PS    = 9'b001000000,
    S_PDRN  = 9'b010000000,
    S_SERVE = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   built_q, built_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    built_d = built_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = start;
        if (start) begin
          if (built_q) begin
            cmd_o.issue = 1'b1;
          end else begin
            cmd_o.init_start = 1'b1;
            state_d          = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.last) begin
          cmd_o.p_start = 1'b1;
          state_d       = S_PRD;
        end
      end
      S_PRD: begin
        if (sts_i.p_done) begin
          cmd_o.ps_start = 1'b1;
          state_d        = S_PS;
        end else begin
          cmd_o.rd_p = 1'b1;
          state_d    = S_PCHK;
        end
      end
      S_PCHK: begin
        if (sts_i.p_prime) begin
          cmd_o.m_start = 1'b1;
          state_d       = S_MRD;
        end else begin
          cmd_o.p_next = 1'b1;
          state_d      = S_PRD;
        end
      end
      S_MRD: begin
        cmd_o.rd_m = 1'b1;
        state_d    = S_MCHK;
      end
      S_MCHK: begin
        cmd_o.chk_m = 1'b1;
        if (sts_i.m_last) begin
          cmd_o.p_next = 1'b1;
          state_d      = S_PRD;
        end else begin
          state_d = S_MRD;
        end
      end
      S_PS: begin
        cmd_o.ps_step = 1'b1;
        if (sts_i.last) begin
          state_d = S_PDRN;
        end
      end
      S_PDRN: begin
        // last prefix entry is written this cycle
        built_d = 1'b1;
        state_d = S_SERVE;
      end
      S_SERVE: begin
        cmd_o.issue = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      built_q <= 1'b0;
    end else begin
      state_q <= state_d;
      built_q <= built_d;
    end
  end

  `SPFPS_ASSERT_NXT(a_built_sticky, built_q, built_q, "tables lost built flag")
  `SPFPS_ASSERT_IMP(a_built_no_build, built_q, (state_q == S_IDLE) || (state_q == S_SERVE),
                    "table build running after tables were built")
  `SPFPS_ASSERT_IMP(a_issue_built, cmd_o.issue, built_q, "sum read before tables built")

endmodule

`default_nettype wire

// ===== rtl/spfps_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "smallest_prime_factor_prefix_sum_assert.svh"

module spfps_dp import spfps_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [QIDX_W-1:0] query_index_i,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  output logic                   done_o,
  output logic      [SUM_W-1:0]  prefix_sum_o
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned CW = ((AW > QIDX_W) ? AW : QIDX_W) + 1;

  // Counters and pipe control
  logic [AW-1:0] i_q, i_d;
  logic [AW-1:0] p_q, p_d;
  logic [AW+1:0] sq_q, sq_d;
  logic [AW:0]   m_q, m_d;
  logic [AW:0]   m_nx;
  logic          v1_q;
  logic          rd_pend_q;
  logic          done_q;

  // Payload
  logic [AW-1:0]    q_q;
  logic [AW-1:0]    q_sat;
  logic [AW-1:0]    idx1_q;
  logic [SUM_W-1:0] acc_q, acc_nx;

  // Memory ports
  logic             f_we, f_re, f_match;
  logic [AW-1:0]    f_waddr, f_wdata, f_raddr, f_rdata;
  logic [SUM_W-1:0] s_rdata;

  // Saturate index to the table
  assign q_sat = (CW'(query_index_i) >= CW'(TABLE_SIZE)) ? AW'(TABLE_SIZE - 1)
                                                         : AW'(query_index_i);

  // Factor table port selection
  assign f_match = (f_rdata == m_q[AW-1:0]);
  assign f_we    = cmd_i.init_step | (cmd_i.chk_m & f_match);
  assign f_waddr = cmd_i.init_step ? i_q : m_q[AW-1:0];
  assign f_wdata = cmd_i.init_step ? i_q : p_q;
  assign f_re    = cmd_i.rd_p | cmd_i.rd_m | cmd_i.ps_step;
  assign f_raddr = cmd_i.rd_p ? p_q : (cmd_i.rd_m ? m_q[AW-1:0] : i_q);

  // Counter updates
  assign m_nx = m_q + {1'b0, p_q};

  always_comb begin
    i_d  = i_q;
    p_d  = p_q;
    sq_d = sq_q;
    m_d  = m_q;
    if (cmd_i.init_start || cmd_i.ps_start) begin
      i_d = '0;
    end else if (cmd_i.init_step || cmd_i.ps_step) begin
      i_d = i_q + AW'(1);
    end
    if (cmd_i.p_start) begin
      p_d  = AW'(2);
      sq_d = (AW + 2)'(4);
    end else if (cmd_i.p_next) begin
      // (p+1)^2 = p^2 + 2p + 1
      p_d  = p_q + AW'(1);
      sq_d = sq_q + (AW + 2)'({p_q, 1'b1});
    end
    if (cmd_i.m_start) begin
      m_d = sq_q[AW:0];
    end else if (cmd_i.chk_m) begin
      m_d = m_nx;
    end
  end

  // Status
  assign sts_o.last    = (i_q == AW'(TABLE_SIZE - 1));
  assign sts_o.p_done  = (sq_q >= (AW + 2)'(TABLE_SIZE));
  assign sts_o.p_prime = (f_rdata == p_q);
  assign sts_o.m_last  = (m_nx >= (AW + 1)'(TABLE_SIZE));

  // Prefix accumulate: entries 0 and 1 hold zero
  assign acc_nx = (idx1_q < AW'(2)) ? '0 : (acc_q + SUM_W'(f_rdata));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q       <= '0;
      p_q       <= '0;
      sq_q      <= '0;
      m_q       <= '0;
      v1_q      <= 1'b0;
      rd_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      i_q       <= i_d;
      p_q       <= p_d;
      sq_q      <= sq_d;
      m_q       <= m_d;
      v1_q      <= cmd_i.ps_step;
      rd_pend_q <= cmd_i.issue;
      done_q    <= rd_pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      q_q <= q_sat;
    end
    if (cmd_i.ps_step) begin
      idx1_q <= i_q;
    end
    if (v1_q) begin
      acc_q <= acc_nx;
    end
  end

  spfps_ram #(
    .W (AW),
    .D (TABLE_SIZE)
  ) u_factor_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .re_i    (f_re),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  spfps_ram #(
    .W (SUM_W),
    .D (TABLE_SIZE)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (idx1_q),
    .wdata_i (acc_nx),
    .re_i    (rd_pend_q),
    .raddr_i (q_q),
    .rdata_o (s_rdata)
  );

  assign done_o       = done_q;
  assign prefix_sum_o = s_rdata;

  `SPFPS_ASSERT_IMP(a_mark_below_index, cmd_i.chk_m && f_match, p_q < m_q[AW-1:0],
                    "marking wrote a factor not below its index")
  `SPFPS_ASSERT_IMP(a_prefix_no_result, v1_q, !rd_pend_q && !done_q,
                    "result request overlaps prefix pass")
  `SPFPS_ASSERT_NXT(a_m_in_table, cmd_i.m_start, m_q < (AW + 1)'(TABLE_SIZE),
                    "first multiple outside the table")

endmodule

`default_nettype wire

// ===== rtl/smallest_prime_factor_prefix_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Smallest-prime-factor prefix sum: a request query_index_i = n returns
// prefix_sum_o = sum of spf(k) for 2 <= k <= n (zero below 2); n at or above
// TABLE_SIZE reads entry TABLE_SIZE-1.
// Request channel: taken at a rising edge with start high and busy low.
// Result channel: done_o is high for exactly one cycle with prefix_sum_o valid;
// the receiver cannot stall, so results are never held back.
// After reset the tables are empty. The first request starts the build, with
// busy high throughout: an identity fill, then a sieve that reads and checks
// factor[p] for each p with p*p < TABLE_SIZE, makes a final bound check, and
// reads and then checks each multiple visited in the factor table, then the
// prefix sums, then a drain state and a state that issues the sum read;
// done_o follows the issue through the read-pending and done registers.
// Later requests are one sum-table read each: busy stays low, done_o
// follows the request through the same registers, and a new request may be
// taken every cycle. Reset drops any request in flight and the built tables.
module smallest_prime_factor_prefix_sum import spfps_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [QIDX_W-1:0] query_index_i,
  output logic                   done_o,
  output logic      [SUM_W-1:0]  prefix_sum_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  spfps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Counters, tables and result path
  spfps_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .query_index_i (query_index_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .done_o        (done_o),
    .prefix_sum_o  (prefix_sum_o)
  );

endmodule

`default_nettype wire
